FILE: rtl/window_function_apply_unit_assert.svh
// Assertion macros shared by the window function apply unit.
// Each macro expects clk and rst in the enclosing module.
`ifndef WINDOW_FUNCTION_APPLY_UNIT_ASSERT_SVH
`define WINDOW_FUNCTION_APPLY_UNIT_ASSERT_SVH

// Property must hold at every edge outside reset.
`define WFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define WFA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/wfa_pkg.sv
// ----------------------------------------------------------------------------
// wfa_pkg
// Types, constants and tables shared by the window function apply unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfa_pkg;

  localparam int MAX_LENGTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int KIND_W      = 3;
  localparam int LENGTH_W    = 11;
  localparam int SHAPE_W     = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_KIND   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RECT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HANN     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BLACKMAN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BHARRIS  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_KAISER   = 3'd5;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;
  localparam logic [SHAPE_W-1:0]  SHAPE_RESET  = 13'd1280;

  localparam logic [15:0] COEF_ONE      = 16'd32768;
  localparam logic [5:0]  SERIES_TERMS  = 6'd50;
  localparam logic [3:0]  CORDIC_LAST   = 4'd15;
  localparam logic [4:0]  SQRT_LAST     = 5'd31;
  localparam logic [5:0]  DIV_LAST      = 6'd63;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [39:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM_X,
    ST_DISPATCH,
    ST_BS_Y,
    ST_BS_MHI,
    ST_BS_MLO,
    ST_BS_DIV_GO,
    ST_BS_DIV_WAIT,
    ST_BS_END,
    ST_FRAC_GO,
    ST_FRAC_WAIT,
    ST_CS_INIT,
    ST_CS_ITER,
    ST_CS_MUL,
    ST_CS_ACC,
    ST_CS_CLAMP,
    ST_KZ_M,
    ST_KZ_SQ,
    ST_KZ_U_GO,
    ST_KZ_U_WAIT,
    ST_KZ_X,
    ST_KZ_CMP,
    ST_KZ_SH,
    ST_KZ_Q_GO,
    ST_KZ_Q_WAIT,
    ST_MUL,
    ST_RND,
    ST_DONE
  } back_state_t;

  // arctangent of 2^-i in turns of 2^32 per circle
  function automatic logic [29:0] atan_turn(input logic [3:0] i);
    logic [29:0] v;
    unique case (i)
      4'd0:  v = 30'd536870912;
      4'd1:  v = 30'd316933406;
      4'd2:  v = 30'd167458907;
      4'd3:  v = 30'd85004756;
      4'd4:  v = 30'd42667331;
      4'd5:  v = 30'd21354465;
      4'd6:  v = 30'd10680862;
      4'd7:  v = 30'd5340245;
      4'd8:  v = 30'd2670163;
      4'd9:  v = 30'd1335087;
      4'd10: v = 30'd667544;
      4'd11: v = 30'd333772;
      4'd12: v = 30'd166886;
      4'd13: v = 30'd83443;
      4'd14: v = 30'd41722;
      4'd15: v = 30'd20861;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // cosine-sum weight of harmonic h, Q2.30
  function automatic logic [29:0] cos_term(input logic [KIND_W-1:0] kind,
                                           input logic [1:0] h);
    logic [29:0] v;
    v = 30'd0;
    unique case (kind)
      KIND_HANN:     v = (h < 2'd2) ? 30'd536870912 : 30'd0;
      KIND_HAMMING: begin
        unique case (h)
          2'd0:    v = 30'd578059648;
          2'd1:    v = 30'd495682176;
          default: v = 30'd0;
        endcase
      end
      KIND_BLACKMAN: begin
        unique case (h)
          2'd0:    v = 30'd450971566;
          2'd1:    v = 30'd536870912;
          2'd2:    v = 30'd85899346;
          default: v = 30'd0;
        endcase
      end
      KIND_BHARRIS: begin
        unique case (h)
          2'd0: v = 30'd385204879;
          2'd1: v = 30'd524297395;
          2'd2: v = 30'd151698245;
          2'd3: v = 30'd12541305;
          default: v = 30'd0;
        endcase
      end
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] cos_harmonics(input logic [KIND_W-1:0] kind);
    logic [1:0] v;
    unique case (kind)
      KIND_BLACKMAN: v = 2'd2;
      KIND_BHARRIS:  v = 2'd3;
      default:       v = 2'd1;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/wfa_queue.sv
// ----------------------------------------------------------------------------
// wfa_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_function_apply_unit_assert.svh"

module wfa_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import wfa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `WFA_NEVER(a_push_full, push && full, "queue written while full")
  `WFA_NEVER(a_pop_empty, pop && empty, "queue read while empty")
  `WFA_NEVER(a_count_over, count > CNT_W'(QUEUE_DEPTH), "queue count above depth")

endmodule

FILE: rtl/wfa_front.sv
// ----------------------------------------------------------------------------
// wfa_front
// Accepts samples, tracks the window position and queues the work word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfa_front #(
  parameter int MAX_LENGTH  = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ITEM_W      = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [wfa_pkg::KIND_W-1:0]            window_kind,
  input  logic [wfa_pkg::LENGTH_W-1:0]          window_length,
  input  logic [wfa_pkg::SHAPE_W-1:0]           kaiser_shape,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [ITEM_W-1:0]                     q_data
);
  import wfa_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH);
  localparam int LEN_W = ($clog2(MAX_LENGTH + 1) > LENGTH_W) ?
                         $clog2(MAX_LENGTH + 1) : LENGTH_W;

  logic [POS_W-1:0] position, position_next;
  logic [LEN_W-1:0] len_ext, len_c;
  logic [POS_W-1:0] last, n;
  logic             wend;

  always_comb begin
    len_ext = LEN_W'(window_length);
    if (len_ext < LEN_W'(2)) begin
      len_c = LEN_W'(2);
    end else if (len_ext > LEN_W'(MAX_LENGTH)) begin
      len_c = LEN_W'(MAX_LENGTH);
    end else begin
      len_c = len_ext;
    end
    last          = POS_W'(len_c - LEN_W'(1));
    n             = (position > last) ? last : position;
    wend          = (n == last);
    position_next = wend ? '0 : n + 1'b1;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {sample_in, n, last, window_kind, kaiser_shape, wend, (n == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (q_push) begin
      position <= position_next;
    end
  end

endmodule

FILE: rtl/wfa_div.sv
// ----------------------------------------------------------------------------
// wfa_div
// Shared restoring divider, one quotient bit per cycle, 64-bit quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfa_div (
  input  logic              clk,
  input  logic              rst,
  input  wfa_pkg::div_req_t req,
  output wfa_pkg::div_rsp_t rsp
);
  import wfa_pkg::*;

  logic [39:0] rem, divisor;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        busy, done;
  logic [40:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, quo[63]};
  assign ge     = (rem_sh >= {1'b0, divisor});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? 40'(rem_sh - {1'b0, divisor}) : rem_sh[39:0];
      quo <= {quo[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/wfa_back.sv
// ----------------------------------------------------------------------------
// wfa_back
// Coefficient sequencer: CORDIC cosines, Kaiser series, product and rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_function_apply_unit_assert.svh"

module wfa_back #(
  parameter int MAX_LENGTH  = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ITEM_W      = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [ITEM_W-1:0]             q_data,
  output wfa_pkg::div_req_t             div_req,
  input  wfa_pkg::div_rsp_t             div_rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          window_end
);
  import wfa_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH);
  localparam int PW    = SAMPLE_BITS + 17;

  back_state_t state, state_next;

  // item fields
  logic signed [SAMPLE_BITS-1:0] s_in, samp;
  logic [POS_W-1:0]   n_in, last_in, n, last;
  logic [KIND_W-1:0]  kind_in, kind;
  logic [SHAPE_W-1:0] shape_in, shape;
  logic               wend_in, nl_in, wend;

  // Bessel series
  logic        mode_norm;
  logic [63:0] bessel_norm, term, sum, num, den;
  logic [21:0] bx;
  logic [25:0] by;
  logic [5:0]  k;
  logic [57:0] hi;
  logic [41:0] lo;
  logic [41:0] hh;
  logic [57:0] mlo;
  logic [64:0] top_lo, sum_add;
  logic [63:0] prod_sat;
  logic [11:0] k2;
  logic        bs_finish;
  logic        div_wait;

  // cosine path
  logic [31:0]        frac;
  logic [31:0]        ph;
  logic [1:0]         h;
  logic signed [33:0] w, cx, cy, cz, dx, dy, at, z0, c_out;
  logic               flip;
  logic [3:0]         ci;
  logic signed [30:0] a_s;
  logic signed [31:0] c_s;
  logic signed [63:0] cprod, cmul, csh;
  logic [30:0]        wc;
  logic [31:0]        wr;

  // Kaiser front
  logic [2*POS_W-1:0] m;
  logic [63:0]        sq_v, sq_r, sq_bit, sq_rb, sq_cur;
  logic [4:0]         sq_i;
  logic [16:0]        u;
  logic [29:0]        xm;

  // output product
  logic [15:0]            coef;
  logic signed [PW-1:0]   sprod, smul, srnd;
  logic signed [PW-1:0]   smax, smin;
  logic [SAMPLE_BITS-1:0] res;
  logic                   out_load;

  assign {s_in, n_in, last_in, kind_in, shape_in, wend_in, nl_in} = q_data;

  // ---- combinational datapath helpers ----
  always_comb begin
    hh       = 42'(bx[21:1]) * 42'(bx[21:1]);
    mlo      = 58'(term[31:0]) * 58'(by);
    top_lo   = {1'b0, hi[47:0], 16'b0} + 65'(lo);
    prod_sat = ((hi[57:48] != '0) || top_lo[64]) ? '1 : top_lo[63:0];
    k2       = 12'(k) * 12'(k);
    sum_add  = {1'b0, sum} + {1'b0, div_rsp.quotient};
    bs_finish = (div_rsp.quotient == '0) || (k == SERIES_TERMS);

    z0 = {{2{ph[31]}}, ph};
    dx = cy >>> ci;
    dy = cx >>> ci;
    at = {4'b0, atan_turn(ci)};
    c_out = flip ? -cx : cx;
    a_s   = $signed({1'b0, cos_term(kind, h)});
    c_s   = c_out[31:0];
    cmul  = a_s * c_s;
    csh   = cprod >>> 30;
    if (w < 0) begin
      wc = '0;
    end else if (w > Q30_ONE) begin
      wc = Q30_ONE[30:0];
    end else begin
      wc = w[30:0];
    end
    wr = ({1'b0, wc} + 32'd16384) >> 15;

    sq_rb  = sq_r + sq_bit;
    sq_cur = (sq_i == '0) ? (64'(m) << 32) : sq_v;
    xm     = 30'(shape) * 30'(u);

    smul = samp * $signed({1'b0, coef});
    srnd = (sprod + PW'(16384)) >>> 15;
    smax = {{18{1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    smin = {{18{1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (!q_empty) state_next = nl_in ? ST_NORM_X : ST_DISPATCH;
      ST_NORM_X:      state_next = ST_BS_Y;
      ST_DISPATCH: begin
        unique case (kind)
          KIND_HANN, KIND_HAMMING, KIND_BLACKMAN, KIND_BHARRIS:
                       state_next = ST_FRAC_GO;
          KIND_KAISER: state_next = ST_KZ_M;
          default:     state_next = ST_MUL;
        endcase
      end
      ST_BS_Y:        state_next = ST_BS_MHI;
      ST_BS_MHI:      state_next = ST_BS_MLO;
      ST_BS_MLO:      state_next = ST_BS_DIV_GO;
      ST_BS_DIV_GO:   state_next = ST_BS_DIV_WAIT;
      ST_BS_DIV_WAIT: if (div_rsp.done) state_next = bs_finish ? ST_BS_END : ST_BS_MHI;
      ST_BS_END:      state_next = mode_norm ? ST_DISPATCH : ST_KZ_CMP;
      ST_FRAC_GO:     state_next = ST_FRAC_WAIT;
      ST_FRAC_WAIT:   if (div_rsp.done) state_next = ST_CS_INIT;
      ST_CS_INIT:     state_next = ST_CS_ITER;
      ST_CS_ITER:     if (ci == CORDIC_LAST) state_next = ST_CS_MUL;
      ST_CS_MUL:      state_next = ST_CS_ACC;
      ST_CS_ACC:      state_next = (h == cos_harmonics(kind)) ? ST_CS_CLAMP : ST_CS_INIT;
      ST_CS_CLAMP:    state_next = ST_MUL;
      ST_KZ_M:        state_next = ST_KZ_SQ;
      ST_KZ_SQ:       if (sq_i == SQRT_LAST) state_next = ST_KZ_U_GO;
      ST_KZ_U_GO:     state_next = ST_KZ_U_WAIT;
      ST_KZ_U_WAIT:   if (div_rsp.done) state_next = ST_KZ_X;
      ST_KZ_X:        state_next = ST_BS_Y;
      ST_KZ_CMP:      state_next = (num >= den) ? ST_MUL : ST_KZ_SH;
      ST_KZ_SH:       if (den[63:40] == '0) state_next = ST_KZ_Q_GO;
      ST_KZ_Q_GO:     state_next = ST_KZ_Q_WAIT;
      ST_KZ_Q_WAIT:   if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:         state_next = ST_RND;
      ST_RND:         state_next = ST_DONE;
      ST_DONE:        if (out_load) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    q_pop            = (state == ST_IDLE) && !q_empty;
    out_load         = (state == ST_DONE) && (!out_valid || !out_stall);
    div_wait         = (state == ST_BS_DIV_WAIT) || (state == ST_FRAC_WAIT) ||
                       (state == ST_KZ_U_WAIT) || (state == ST_KZ_Q_WAIT);
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      ST_BS_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_sat;
        div_req.divisor  = 40'(k2);
      end
      ST_FRAC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(n) << 32;
        div_req.divisor  = 40'(last);
      end
      ST_KZ_U_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sq_r << 1;
        div_req.divisor  = 40'(last);
      end
      ST_KZ_Q_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = (num << 15) + (den >> 1);
        div_req.divisor  = den[39:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      bessel_norm <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_BS_END && mode_norm) begin
        bessel_norm <= sum;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          samp      <= s_in;
          n         <= n_in;
          last      <= last_in;
          kind      <= kind_in;
          shape     <= shape_in;
          wend      <= wend_in;
          mode_norm <= nl_in;
        end
      end
      ST_NORM_X:   bx <= 22'({shape, 8'b0});
      ST_DISPATCH: coef <= COEF_ONE;
      ST_BS_Y: begin
        by   <= hh[41:16];
        term <= 64'd65536;
        sum  <= 64'd65536;
        k    <= 6'd1;
      end
      ST_BS_MHI:   hi <= 58'(term[63:32]) * 58'(by);
      ST_BS_MLO:   lo <= mlo[57:16];
      ST_BS_DIV_WAIT: begin
        if (div_rsp.done) begin
          term <= div_rsp.quotient;
          if (div_rsp.quotient != '0) begin
            sum <= sum_add[64] ? '1 : sum_add[63:0];
          end
          k <= k + 1'b1;
        end
      end
      ST_BS_END: begin
        num <= sum;
        den <= (bessel_norm == '0) ? 64'd65536 : bessel_norm;
      end
      ST_FRAC_WAIT: begin
        if (div_rsp.done) begin
          frac <= div_rsp.quotient[31:0];
          ph   <= div_rsp.quotient[31:0];
          h    <= 2'd1;
          w    <= $signed({4'b0, cos_term(kind, 2'd0)});
        end
      end
      ST_CS_INIT: begin
        // fold angles beyond a quarter turn and negate the result
        if (z0 > QUARTER_TURN) begin
          cz   <= z0 - HALF_TURN;
          flip <= 1'b1;
        end else if (z0 < -QUARTER_TURN) begin
          cz   <= z0 + HALF_TURN;
          flip <= 1'b1;
        end else begin
          cz   <= z0;
          flip <= 1'b0;
        end
        cx <= CORDIC_GAIN;
        cy <= '0;
        ci <= '0;
      end
      ST_CS_ITER: begin
        if (cz >= 0) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
        ci <= ci + 1'b1;
      end
      ST_CS_MUL:   cprod <= cmul;
      ST_CS_ACC: begin
        if (h[0]) begin
          w <= w - $signed(csh[33:0]);
        end else begin
          w <= w + $signed(csh[33:0]);
        end
        h  <= h + 1'b1;
        ph <= ph + frac;
      end
      ST_CS_CLAMP: coef <= wr[15:0];
      ST_KZ_M: begin
        m      <= (2*POS_W)'(n) * (2*POS_W)'(last - n);
        sq_r   <= '0;
        sq_bit <= 64'd1 << 62;
        sq_i   <= '0;
      end
      ST_KZ_SQ: begin
        // first step runs against the fresh operand
        if (sq_cur >= sq_rb) begin
          sq_v <= sq_cur - sq_rb;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_v <= sq_cur;
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_i   <= sq_i + 1'b1;
      end
      ST_KZ_U_WAIT: begin
        if (div_rsp.done) begin
          u <= (div_rsp.quotient > 64'd65536) ? 17'd65536 : div_rsp.quotient[16:0];
        end
      end
      ST_KZ_X: begin
        bx        <= xm[29:8];
        mode_norm <= 1'b0;
      end
      ST_KZ_CMP:   coef <= COEF_ONE;
      ST_KZ_SH: begin
        if (den[63:40] != '0) begin
          den <= den >> 1;
          num <= num >> 1;
        end
      end
      ST_KZ_Q_WAIT: if (div_rsp.done) coef <= div_rsp.quotient[15:0];
      ST_MUL:      sprod <= smul;
      ST_RND: begin
        if (srnd > smax) begin
          res <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (srnd < smin) begin
          res <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
          res <= srnd[SAMPLE_BITS-1:0];
        end
      end
      ST_DONE: begin
        if (out_load) begin
          sample_out <= $signed(res);
          window_end <= wend;
        end
      end
      default: ;
    endcase
  end

  `WFA_ASSERT(a_coef_unity, (state == ST_MUL) |-> (coef <= COEF_ONE), "coefficient above unity")
  `WFA_ASSERT(a_div_expected, div_rsp.done |-> div_wait, "divider finished outside a wait state")
  `WFA_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sample_out)), "stalled word changed")

endmodule

FILE: rtl/window_function_apply_unit.sv
// ----------------------------------------------------------------------------
// window_function_apply_unit
// Multiplies a sample stream by a configurable window (cosine sums, Kaiser).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one sample word; output channel
//   out_valid / out_stall returns one windowed word plus window_end per input.
//   A word moves when valid is high and stall is low at a rising edge.
//   Config writes (cfg_write, cfg_index, cfg_data) are registered; write
//   only while no sample is in flight. Index 3 is ignored.
// Timing:
//   The front takes a word and queues it (two entries), so input
//   keeps flowing while a result waits on a stalled receiver.
//   The back works one word at a time; the shared divider and the
//   16-step CORDIC set the pace. Rectangular is quickest; the cosine sums
//   slow down with each harmonic, and Kaiser adds a Bessel series of up
//   to 50 terms.
//   Position 0 of each window adds one extra series for the normalizer.
// Reset:
//   Synchronous, active high; clears the position, the normalizer, both
//   channels and the config registers to Hann-free rectangular, 1024, beta 5.
//   A stalled receiver holds the result; the queue fills then in_stall rises.
`timescale 1ns / 1ps

module window_function_apply_unit #(
  parameter int MAX_LENGTH  = wfa_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = wfa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [wfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic                                window_end
);
  import wfa_pkg::*;

  localparam int POS_W  = $clog2(MAX_LENGTH);
  // sample, position, last index, kind, shape, end flag, norm reload flag
  localparam int ITEM_W = SAMPLE_BITS + 2*POS_W + KIND_W + SHAPE_W + 2;

  logic [KIND_W-1:0]   window_kind;
  logic [LENGTH_W-1:0] window_length;
  logic [SHAPE_W-1:0]  kaiser_shape;

  logic              q_push, q_pop, q_full, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind   <= KIND_RECT;
      window_length <= LENGTH_RESET;
      kaiser_shape  <= SHAPE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KIND:   window_kind   <= cfg_data[KIND_W-1:0];
        REG_LENGTH: window_length <= cfg_data[LENGTH_W-1:0];
        REG_SHAPE:  kaiser_shape  <= cfg_data[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  wfa_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .window_kind  (window_kind),
    .window_length(window_length),
    .kaiser_shape (kaiser_shape),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  wfa_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  wfa_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  wfa_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .window_end(window_end)
  );

endmodule

FILE: tb/window_function_apply_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_function_apply_unit_tb
// Drives sample words through the window unit under every window kind, many
// lengths and Kaiser shapes, with random gaps and receiver stalls. A bit-exact
// model of the windowing arithmetic in the bench predicts each output word.
// ----------------------------------------------------------------------------
module window_function_apply_unit_tb;
  import wfa_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;   // no register here
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 40000;   // worst Kaiser word plus long hold
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 40;      // result count that arms the hold
  localparam int HOLD_PENDING = 8;       // fewest words still to send for it to start

  localparam longint A_HAM0 = 578059648,  A_HAM1 = 495682176;
  localparam longint A_BL0  = 450971566,  A_BL1  = 536870912, A_BL2 = 85899346;
  localparam longint A_BH0  = 385204879,  A_BH1  = 524297395;
  localparam longint A_BH2  = 151698245,  A_BH3  = 12541305;
  localparam longint HALF_Q30 = 536870912;
  localparam longint ONE_Q30  = 1073741824;
  localparam bit [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 last;
  } windowed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] sample_out;
  logic window_end;

  window_function_apply_unit uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .window_end(window_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow of the unit's registers and state
  logic [KIND_W-1:0]   sh_kind  = KIND_RECT;
  logic [LENGTH_W-1:0] sh_len   = LENGTH_RESET;
  logic [SHAPE_W-1:0]  sh_shape = SHAPE_RESET;
  int unsigned         win_pos  = 0;
  bit [63:0]           i0_norm  = 0;

  logic signed [SW-1:0] samples_to_send[$];
  windowed_t            windowed_due[$];
  int unsigned words_queued = 0;
  int unsigned words_checked = 0;
  int unsigned errors = 0;

  // --------------------------------------------------------------------------
  // Windowing arithmetic
  // --------------------------------------------------------------------------
  function automatic longint atan_step(int i);
    longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                      21354465, 10680862, 5340245, 2670163, 1335087, 667544,
                      333772, 166886, 83443, 41722, 20861};
    return t[i];
  endfunction

  // Q2.30 cosine of a phase in turns of 2^32; shifts floor (>>> on longint)
  function automatic longint cordic_cosine(bit [31:0] phase);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({32'b0, phase});
    if (phase[31]) z = z - 64'sd4294967296;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > ONE_Q30) begin
      z = z - 2 * ONE_Q30; flip = 1'b1;
    end else if (z < -ONE_Q30) begin
      z = z + 2 * ONE_Q30; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step(i);
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic bit [15:0] cosine_sum_coef(bit [63:0] frac, longint a0,
                                                longint a1, longint a2,
                                                longint a3);
    longint w;
    bit [63:0] f2, f3;
    f2 = frac * 2;
    f3 = frac * 3;
    w = a0;
    w = w - ((a1 * cordic_cosine(frac[31:0])) >>> 30);
    w = w + ((a2 * cordic_cosine(f2[31:0])) >>> 30);
    w = w - ((a3 * cordic_cosine(f3[31:0])) >>> 30);
    if (w < 0) w = 0;
    if (w > ONE_Q30) w = ONE_Q30;
    return 16'((w + 16384) >> 15);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q.16 product, saturating at the top of 64 bits
  function automatic bit [63:0] q16_mul_sat(bit [63:0] a, bit [31:0] b);
    bit [63:0] hi, lo, top;
    hi = (a >> 32) * {32'b0, b};
    lo = ((a & 64'hFFFF_FFFF) * {32'b0, b}) >> 16;
    if (hi >= (64'd1 << 48)) return U64_MAX;
    top = hi << 16;
    return (top > U64_MAX - lo) ? U64_MAX : top + lo;
  endfunction

  // zeroth-order modified Bessel, Q.16 in and out, at most 50 terms
  function automatic bit [63:0] bessel_q16(bit [63:0] x);
    bit [63:0] h, hh, term, sum;
    bit [31:0] y;
    h = x >> 1;
    hh = (h * h) >> 16;
    y = hh[31:0];
    term = 65536;
    sum = 65536;
    for (int k = 1; k <= 50; k++) begin
      term = q16_mul_sat(term, y) / 64'(k * k);
      if (term == 0) break;
      sum = (sum > U64_MAX - term) ? U64_MAX : sum + term;
    end
    return sum;
  endfunction

  function automatic bit [15:0] kaiser_weight(bit [63:0] n, bit [63:0] last);
    bit [63:0] r, u, num, den;
    r = int_sqrt((n * (last - n)) << 32);
    u = (2 * r) / last;
    if (u > 65536) u = 65536;
    num = bessel_q16(({51'b0, sh_shape} * u) >> 8);
    den = i0_norm;
    if (den == 0) den = 65536;
    if (num >= den) return COEF_ONE;
    while (den >= (64'd1 << 40)) begin
      den = den >> 1; num = num >> 1;
    end
    return 16'((num * 32768 + den / 2) / den);
  endfunction

  // Works out the windowed word for one accepted sample and files it.
  function automatic void predict_windowed(logic signed [SW-1:0] s);
    bit [63:0] len, last, n, frac;
    bit [15:0] coef;
    longint p;
    windowed_t w;
    len = sh_len;
    if (len < 2) len = 2;
    if (len > MAX_LENGTH_DEF) len = MAX_LENGTH_DEF;
    last = len - 1;
    n = win_pos;
    if (n > last) n = last;
    // normalizer only refreshes at the window start
    if (n == 0) i0_norm = bessel_q16({51'b0, sh_shape} << 8);
    frac = (n << 32) / last;
    case (sh_kind)
      KIND_HANN:     coef = cosine_sum_coef(frac, HALF_Q30, HALF_Q30, 0, 0);
      KIND_HAMMING:  coef = cosine_sum_coef(frac, A_HAM0, A_HAM1, 0, 0);
      KIND_BLACKMAN: coef = cosine_sum_coef(frac, A_BL0, A_BL1, A_BL2, 0);
      KIND_BHARRIS:  coef = cosine_sum_coef(frac, A_BH0, A_BH1, A_BH2, A_BH3);
      KIND_KAISER:   coef = kaiser_weight(n, last);
      default:       coef = COEF_ONE;   // rectangular and the spare kinds
    endcase
    p = (longint'(s) * longint'({48'b0, coef}) + 16384) >>> 15;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    w.value = SW'(p);
    w.last = (n == last);
    win_pos = w.last ? 0 : int'(n) + 1;
    windowed_due.push_back(w);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Sender: one word per queue entry, a random gap between words,
  // with occasional gap-free bursts.
  // --------------------------------------------------------------------------
  int  send_gap = 0;
  bit  send_burst = 1'b0;

  always @(posedge clk) begin
    logic next_valid;
    next_valid = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_windowed(sample_in);
      if (in_valid && in_stall) begin
        next_valid = 1'b1;                 // hold the stalled word
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (samples_to_send.size() > 0) begin
        sample_in <= samples_to_send.pop_front();
        next_valid = 1'b1;
        if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 3);
      end
      in_valid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Long hold: once, with plenty of words still to send, the receiver holds
  // off so the unit backs up into in_stall.
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && words_checked >= HOLD_AT &&
                 samples_to_send.size() >= HOLD_PENDING) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each word against the oldest prediction, then stalls
  // for a random spell.
  // --------------------------------------------------------------------------
  int  recv_wait = 0;
  bit  recv_burst = 1'b0;

  always @(posedge clk) begin
    windowed_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (windowed_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %0d", sample_out));
        end else begin
          w = windowed_due.pop_front();
          if (sample_out !== w.value)
            flag_mismatch($sformatf("word %0d: sample_out %0d, want %0d",
                                    words_checked, sample_out, w.value));
          if (window_end !== w.last)
            flag_mismatch($sformatf("word %0d: window_end %b, want %b",
                                    words_checked, window_end, w.last));
        end
        if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left > 0);
      end
    end
  end

  // Watchdog: only counts while words are outstanding and nothing moves.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        words_checked == words_queued) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KIND:   sh_kind  = value[KIND_W-1:0];
      REG_LENGTH: sh_len   = value[LENGTH_W-1:0];
      REG_SHAPE:  sh_shape = value[SHAPE_W-1:0];
      default: ;                         // spare index: no effect
    endcase
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
      default: return SW'($urandom);
    endcase
  endfunction

  // Waits for the unit to drain, reprograms it, then queues a batch.
  task automatic run_batch(input logic [KIND_W-1:0] kind,
                           input logic [CFG_DATA_W-1:0] len,
                           input logic [CFG_DATA_W-1:0] shape,
                           input int count, input bit directed_edges);
    logic signed [SW-1:0] edges[5] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                       16'shFFFF, 16'sh0001};
    wait (words_checked == words_queued);
    repeat (4) @(posedge clk);
    write_reg(REG_KIND, CFG_DATA_W'(kind));
    write_reg(REG_LENGTH, len);
    write_reg(REG_SHAPE, shape);
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int i = 0; i < count; i++) begin
      samples_to_send.push_back(directed_edges ? edges[i % 5] : pick_sample());
      words_queued++;
    end
  endtask

  initial begin
    logic [KIND_W-1:0] kind;
    logic [CFG_DATA_W-1:0] len, shape;
    int count;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // spare register index must leave everything alone
    write_reg(REG_SPARE, 13'h1FFF);
    @(posedge clk);
    cfg_write <= 1'b0;

    // directed: edge samples, short and clamped lengths, every kind
    run_batch(KIND_RECT, 13'd0, 13'd1280, 5, 1'b1);
    run_batch(KIND_HANN, 13'd1, 13'd1280, 3, 1'b1);
    run_batch(KIND_HAMMING, 13'd3, 13'd1280, 3, 1'b1);
    run_batch(KIND_BLACKMAN, 13'd2047, 13'd1280, 2, 1'b1);
    run_batch(KIND_BHARRIS, 13'd5, 13'd1280, 3, 1'b1);
    run_batch(KIND_KAISER, 13'd5, 13'd8191, 3, 1'b1);
    // shape changed mid-window: norm stays, length shrunk below position
    run_batch(KIND_KAISER, 13'd2, 13'd0, 2, 1'b1);
    run_batch(KIND_SPARE6, 13'd1024, 13'd0, 2, 1'b1);
    run_batch(KIND_SPARE7, 13'd4, 13'd0, 2, 1'b1);

    // random batches, mostly short windows so they wrap often
    while (words_queued < RANDOM_WORDS + 25) begin
      kind = KIND_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) len = CFG_DATA_W'($urandom_range(1000, 2047));
      else len = CFG_DATA_W'($urandom_range(0, 40));
      case ($urandom_range(0, 5))
        0: shape = 13'd0;
        1: shape = 13'd8191;
        default: shape = CFG_DATA_W'($urandom_range(0, 8191));
      endcase
      if (kind == KIND_KAISER) count = $urandom_range(4, 12);
      else count = $urandom_range(10, 40);
      run_batch(kind, len, shape, count, 1'b0);
    end

    wait (words_checked == words_queued);
    repeat (200) @(posedge clk);
    if (errors == 0 && windowed_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
